[sv/hbp_pkg.sv]
// Shared types and constants for the Huffman bit packer.
// Used by every module of the block except hbp_checker; depends on nothing.
package hbp_pkg;

  localparam int unsigned NUM_SYMBOLS  = 128;
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned SYM_W  = 7;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BUF_W  = 40;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

  // Longest length that a table entry may hold.
  localparam logic [LEN_W-1:0] CODE_CAP =
    LEN_W'((MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W);

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EMIT,
    B_FLUSH,
    B_PAD
  } bstate_e;

  // One command passed from the front to the back.
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } qentry_t;

endpackage

[sv/hbp_front.sv]
// Front of the bit packer: accepts items, owns the code table memory and
// turns encode and flush items into queue commands. Depends on hbp_pkg.
module hbp_front
  import hbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [CODE_W-1:0] code_value_i,
  input  logic [LEN_W-1:0]  code_length_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output qentry_t           push_data_o
);

  logic [CODE_W+LEN_W-1:0] tbl_q [NUM_SYMBOLS];
  logic [CODE_W+LEN_W-1:0] rd_q;
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_flush_q, s1_flush_d;

  logic              advance;
  logic              accept;
  logic [SYM_W+1:0]  sym_ext;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   mask_w;
  logic              wr_en;
  logic              rd_en;

  assign advance    = !s1_valid_q || push_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  assign sym_ext  = {2'b00, symbol_i};
  assign in_range = sym_ext < (SYM_W+2)'(NUM_SYMBOLS);
  assign idx      = sym_ext[IDX_W-1:0];

  // Saturate the length, then drop stray code bits above it.
  assign len_sat = (code_length_i > CODE_CAP) ? CODE_CAP : code_length_i;
  assign mask_w  = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);

  assign wr_en = accept && (op_i == OP_WRITE) && in_range;
  assign rd_en = accept && (op_i == OP_ENCODE) && in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[idx] <= {code_value_i & mask_w[CODE_W-1:0], len_sat};
    end
    if (rd_en) begin
      rd_q <= tbl_q[idx];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_flush_d = s1_flush_q;
    if (advance) begin
      s1_valid_d = rd_en || (accept && (op_i == OP_FLUSH));
      s1_flush_d = (op_i == OP_FLUSH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
    end
  end

  assign push_valid_o         = s1_valid_q;
  assign push_data_o.is_flush = s1_flush_q;
  assign push_data_o.code     = rd_q[CODE_W+LEN_W-1:LEN_W];
  assign push_data_o.len      = rd_q[LEN_W-1:0];

endmodule

[sv/hbp_queue.sv]
// Short command queue between the front and the back of the bit packer.
// Depends on hbp_pkg.
module hbp_queue
  import hbp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  qentry_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output qentry_t pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  qentry_t          mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   fill_q, fill_d;
  logic             push;
  logic             pop;

  assign push_ready_o = fill_q != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

[sv/hbp_back.sv]
// Back of the bit packer: executes queued commands on the bit buffer and
// drives the registered byte output. Depends on hbp_pkg.
module hbp_back
  import hbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  qentry_t           pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_last_o
);

  bstate_e           state_q, state_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ovalid_q, ovalid_d;
  logic [BYTE_W-1:0] obyte_q, obyte_d;
  logic              olast_q, olast_d;

  logic              out_free;
  logic              more;
  logic [BUF_W-1:0]  emit_sh;
  logic [3:0]        pad;
  logic [BYTE_W-1:0] low_bits;
  logic [BYTE_W-1:0] pad_byte;

  assign out_free = !ovalid_q || out_ready_i;
  assign more     = cnt_q > CNT_W'(BYTE_W);
  assign emit_sh  = buf_q >> (cnt_q - CNT_W'(BYTE_W));
  assign pad      = 4'(BYTE_W) - cnt_q[3:0];
  assign low_bits = buf_q[BYTE_W-1:0] & ~(8'hFF << cnt_q[3:0]);
  assign pad_byte = low_bits << pad;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_data_i.is_flush ? B_FLUSH : B_EMIT;
        end
      end
      B_EMIT: begin
        if (!more) begin
          state_d = B_IDLE;
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          state_d = B_PAD;
        end
      end
      B_PAD: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = 1'b0;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    case (state_q)
      B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i && !pop_data_i.is_flush) begin
          buf_d = (buf_q << pop_data_i.len) | BUF_W'(pop_data_i.code);
          cnt_d = cnt_q + pop_data_i.len;
        end
      end
      B_EMIT: begin
        if (more && out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = emit_sh[BYTE_W-1:0];
          olast_d  = 1'b0;
          cnt_d    = cnt_q - CNT_W'(BYTE_W);
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = pad_byte;
          olast_d  = 1'b0;
        end
      end
      B_PAD: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obyte_d  = BYTE_W'(pad);
          olast_d  = 1'b1;
          buf_d    = '0;
          cnt_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      buf_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

[sv/huffman_bit_packer_unit.sv]
// Top level of the Huffman bit packer: stream ports, front, queue and back.
// Depends on hbp_pkg, hbp_front, hbp_queue and hbp_back.
//
// Usage:
//   The slave stream carries one item per handshake: a code table write,
//   a symbol to encode, or a flush. Table writes produce no output; an
//   encode appends the symbol's code to the bit buffer, most significant
//   bit first, and sends every complete byte beyond the newest 8 bits; a
//   flush sends the zero-padded remaining bits as one byte, then the pad
//   count with tlast set, and empties the buffer.
//   The table read of an encode happens on the accepting edge; the queue
//   write, the buffer update in the back and the byte emit into the output
//   register follow in that order. The back takes an item only in its idle
//   state; an encode then sends its bytes (at most four) one at a time from
//   the emit state while the output register is free, and a flush passes
//   through the flush and pad states, before the back returns to idle.
//   Table writes complete in the front but, like every item, wait while
//   tready is low.
//   A two-entry queue lets the front keep taking items while the back works.
//   When the master side stalls, the output register holds its byte, the
//   back halts, the queue fills and then tready drops on the slave side.
//   Reset empties the bit buffer, queue and output register; the code
//   table is not cleared and an entry must be written before it is encoded.
module huffman_bit_packer_unit
  import hbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] op, [8:2] symbol, [40:9] code_value, [46:41] code_length, [47] zero
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic    push_valid;
  logic    push_ready;
  qentry_t push_data;
  logic    pop_valid;
  logic    pop_ready;
  qentry_t pop_data;

  // Unpack the item fields and feed the front.
  hbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .op_i          (s_axis_tdata_i[1:0]),
    .symbol_i      (s_axis_tdata_i[8:2]),
    .code_value_i  (s_axis_tdata_i[40:9]),
    .code_length_i (s_axis_tdata_i[46:41]),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  // Decouple the table side from the byte emitter.
  hbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Shift codes into the buffer and drain it byte by byte.
  hbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

[sv/hbp_checker.sv]
// Port-level checks for the Huffman bit packer, bound to its top level.
// Depends on huffman_bit_packer_unit.
module hbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // A stalled output item holds its byte and marker.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // The pad count never exceeds one byte worth of bits.
  a_pad_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o <= 8'd8)
    else $error("pad count out of range");

  // An accepted pad count is never directly followed by another offered pad count.
  a_no_double_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o |=>
      !(m_axis_tvalid_o && m_axis_tlast_o))
    else $error("two pad counts in a row");

  // Nothing is offered on the cycle reset is released.
  a_reset_quiet : assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind huffman_bit_packer_unit hbp_checker u_hbp_checker (.*);

[tb/hbp_packer_checker.sv]
// Scoreboard for the Huffman bit packer: watches both stream ports, predicts the
// packed bytes of every accepted item and compares them in order.
// Depends on hbp_pkg for field widths, the length cap and the op codes.
module hbp_packer_checker
  import hbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [1:0] op, [8:2] symbol, [40:9] code_value, [46:41] code_length, [47] zero
  input  logic [47:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [7:0] out_byte
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_flag;
  } packed_byte_t;

  logic [CODE_W-1:0] code_tab [NUM_SYMBOLS];
  logic [LEN_W-1:0]  len_tab  [NUM_SYMBOLS];
  logic [63:0]       held_bits  = '0;
  int unsigned       held_count = 0;
  packed_byte_t      byte_q[$];
  int                errors = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [63:0] low_bits(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    packed_byte_t rec;
    rec.data_byte = b;
    rec.last_flag = is_last;
    byte_q.insert(byte_q.size(), rec);
  endtask

  // Update the table or the bit buffer and queue the bytes this item sends.
  task automatic pack_item(input logic [47:0] item);
    op_e               op;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] val;
    logic [LEN_W-1:0]  len;
    int unsigned       clen;
    int unsigned       pad;
    op  = op_e'(item[1:0]);
    sym = item[8:2];
    val = item[40:9];
    len = item[46:41];
    case (op)
      OP_WRITE: begin
        if (sym < NUM_SYMBOLS) begin
          if (len > CODE_CAP) len = CODE_CAP;
          code_tab[sym] = CODE_W'(64'(val) & low_bits(len));
          len_tab[sym]  = len;
        end
      end
      OP_ENCODE: begin
        if (sym < NUM_SYMBOLS) begin
          clen       = len_tab[sym];
          held_bits  = ((held_bits << clen) | 64'(code_tab[sym])) & low_bits(BUF_W);
          held_count = held_count + clen;
          // send every whole byte beyond the newest 8 bits, oldest first
          while (held_count > 8) begin
            queue_byte(BYTE_W'(held_bits >> (held_count - 8)), 1'b0);
            held_count = held_count - 8;
            held_bits  = held_bits & low_bits(held_count);
          end
        end
      end
      OP_FLUSH: begin
        pad = 8 - held_count;
        queue_byte(BYTE_W'((held_bits & low_bits(held_count)) << pad), 1'b0);
        queue_byte(BYTE_W'(pad), 1'b1);
        held_bits  = '0;
        held_count = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    packed_byte_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (byte_q.size() == 0) begin
          $error("out_byte 0x%02h last %0b arrived with nothing pending", m_tdata_i, m_tlast_i);
          errors++;
        end else begin
          want = byte_q.pop_front();
          if (m_tdata_i !== want.data_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data_byte, m_tdata_i);
            errors++;
          end
          if (m_tlast_i !== want.last_flag) begin
            $error("last: expected %0b, got %0b", want.last_flag, m_tlast_i);
            errors++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) pack_item(s_tdata_i);
    end
    fail_count_o <= errors;
    pending_o    <= byte_q.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top for huffman_bit_packer_unit: drives table writes, encodes and
// flushes in bursts, stalls the output side, and reports the verdict.
// Depends on hbp_pkg, huffman_bit_packer_unit and hbp_packer_checker.
module tb_top;
  import hbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 300;

  // output-side stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB, RX_HOLD} rx_mode_e;

  logic        clk;
  logic        rst_n;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  int          fail_count;
  int          pending;

  bit          loaded [NUM_SYMBOLS];
  int          loaded_syms[$];
  int          burst_left;
  bit          hold_req = 1'b0;

  huffman_bit_packer_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  hbp_packer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [47:0] make_item(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                            input logic [CODE_W-1:0] val,
                                            input logic [LEN_W-1:0] len);
    return {1'b0, len, val, sym, op};
  endfunction

  // Offer one item and hold it until taken; between bursts drop valid for a gap.
  task automatic push_item(input logic [47:0] item);
    int gap;
    s_tdata  <= item;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  // Write a table entry and remember that it may now be encoded.
  task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] val,
                            input logic [LEN_W-1:0] len);
    push_item(make_item(OP_WRITE, sym, val, len));
    if (!loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), int'(sym));
    end
  endtask

  task automatic encode_sym(input logic [SYM_W-1:0] sym);
    push_item(make_item(OP_ENCODE, sym, $urandom(), LEN_W'($urandom_range(63))));
  endtask

  task automatic flush_stream();
    push_item(make_item(OP_FLUSH, SYM_W'($urandom_range(127)), $urandom(),
                        LEN_W'($urandom_range(63))));
  endtask

  // Output side: alternate stall patterns, with one long hold-off once the
  // random traffic starts so the queue fills and the input side backs up.
  initial begin
    rx_mode_e mode;
    int       seg;
    bit       held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = rx_mode_e'($urandom_range(3));
      seg  = $urandom_range(10, 60);
      if (hold_req && !held) begin
        held = 1'b1;
        mode = RX_HOLD;
        seg  = HOLD_CYCLES;
      end
      for (int k = 0; k < seg; k++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(1));
          RX_MOSTLY: m_tready <= ($urandom_range(3) != 0);
          RX_COMB:   m_tready <= (k % 3 != 0);
          default:   m_tready <= 1'b0;
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int          pick;
    int          sel;
    logic [LEN_W-1:0] len;
    rst_n    <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    burst_left = $urandom_range(1, 20);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of every field, saturation, stray bits, empty codes
    load_entry(0, 32'hFFFF_FFFF, 6'd32);
    load_entry(127, 32'h8000_0001, 6'd0);   // zero-length code
    load_entry(1, 32'hA5A5_A5A5, 6'd63);    // length above the cap
    load_entry(2, 32'hFFFF_FFFE, 6'd1);     // stray bits above the length
    load_entry(3, 32'h0000_01FF, 6'd8);
    load_entry(4, 32'h0000_0005, 6'd3);
    flush_stream();                          // empty buffer: pad of 8
    encode_sym(3);
    flush_stream();                          // exactly one byte held: pad of 0
    encode_sym(0);
    encode_sym(0);                           // buffer reaches 40 bits, four bytes out
    encode_sym(127);
    push_item(make_item(OP_UNUSED, 7'h7F, 32'hFFFF_FFFF, 6'h3F));
    encode_sym(1);
    encode_sym(2);
    encode_sym(4);
    flush_stream();
    encode_sym(4);
    encode_sym(2);
    flush_stream();
    load_entry(5, 32'h0000_0000, 6'd33);
    encode_sym(5);
    encode_sym(0);
    flush_stream();

    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // end the stream with a gap so valid drops right after the last item
      if (i == RANDOM_ITEMS - 1) burst_left = 0;
      pick = $urandom_range(99);
      if (pick < 15) begin
        sel = $urandom_range(9);
        if (sel == 0)      len = '0;
        else if (sel == 1) len = LEN_W'($urandom_range(33, 63));
        else if (sel == 2) len = 6'd32;
        else               len = LEN_W'($urandom_range(1, 31));
        load_entry(SYM_W'($urandom_range(NUM_SYMBOLS - 1)), $urandom(), len);
      end else if (pick < 85) begin
        encode_sym(SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]));
      end else if (pick < 95) begin
        flush_stream();
      end else begin
        push_item(make_item(OP_UNUSED, SYM_W'($urandom_range(127)), $urandom(),
                            LEN_W'($urandom_range(63))));
      end
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
